[src/lst_pkg.sv]
package lst_pkg;

   // default table size
   localparam int SlotsDefault = 16;

   // field widths
   localparam int OpWidth     = 2;
   localparam int IdWidth     = 16;
   localparam int StatusWidth = 3;
   localparam int SlotWidth   = 4;
   localparam int CountWidth  = 5;

   // operation codes
   localparam logic [OpWidth-1:0] OP_LOOKUP  = 2'd0;
   localparam logic [OpWidth-1:0] OP_ALLOC   = 2'd1;
   localparam logic [OpWidth-1:0] OP_DEALLOC = 2'd2;

   // status codes
   localparam logic [StatusWidth-1:0] STATUS_HIT     = 3'd0;
   localparam logic [StatusWidth-1:0] STATUS_MISS    = 3'd1;
   localparam logic [StatusWidth-1:0] STATUS_NEW     = 3'd2;
   localparam logic [StatusWidth-1:0] STATUS_OVERLAY = 3'd3;
   localparam logic [StatusWidth-1:0] STATUS_REMOVED = 3'd4;

   typedef struct packed {
      logic [OpWidth-1:0] operation;
      logic [IdWidth-1:0] cab_id;
   } req_type;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [SlotWidth-1:0]   slot;
      logic [CountWidth-1:0]  entry_count;
   } rsp_type;

endpackage

[src/lru_session_table.sv]
// Session table of SLOTS slots kept in most-recently-used order. A request
// word is taken when start is high and busy is low; busy then stays high until
// the cycle in which the response word is issued. The response appears on
// rsp_word for one cycle with rsp_strobe high and cannot be held off, so the
// receiver must take it when it comes. The search compares one active entry
// per cycle against the id through a single tag memory read port and one
// comparator, in recency order from the front; it stops at a hit, or after
// all active entries on a miss. The recency list is then updated in the
// S_ACT state, which also forms the response word. Unused operation code 3
// skips the search and changes nothing.
module lru_session_table #(
   parameter int SLOTS = lst_pkg::SlotsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lst_pkg::req_type req_word,
   output logic             rsp_strobe,
   output lst_pkg::rsp_type rsp_word
);

   localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_ACT    = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [lst_pkg::OpWidth-1:0] op_ff, op_in;
   logic [lst_pkg::IdWidth-1:0] id_ff, id_in;
   logic [PW-1:0]               order_ff [SLOTS];
   logic [PW-1:0]               order_in [SLOTS];
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               rd_idx_ff, rd_idx_in;
   logic                        cmp_vld_ff, cmp_vld_in;
   logic [PW-1:0]               cmp_pos_ff, cmp_pos_in;
   logic                        found_ff, found_in;
   logic [PW-1:0]               pos_ff, pos_in;
   logic [lst_pkg::IdWidth-1:0] tag_mem_ff [SLOTS];
   logic [lst_pkg::IdWidth-1:0] tag_rd_ff;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   lst_pkg::rsp_type            rsp_word_ff, rsp_word_in;

   logic          accept;
   logic          rd_en;
   logic          wr_en;
   logic          match;
   logic          full;
   logic [PW-1:0] front_pos;
   logic [PW-1:0] sel_slot;
   logic [CW-1:0] new_count;
   logic [31:0]   slot_wide;
   logic [31:0]   count_wide;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);
   assign match  = cmp_vld_ff && (tag_rd_ff == id_ff);
   assign full   = (count_ff == CW'(SLOTS));

   // pick the position moved to front: the hit, or the insert point on a miss
   always_comb begin
      if (found_ff) begin
         front_pos = pos_ff;
      end else if (full) begin
         front_pos = PW'(SLOTS - 1);
      end else begin
         front_pos = count_ff[PW-1:0];
      end
   end

   assign sel_slot = order_ff[front_pos];

   // sequencer and recency list update
   always_comb begin
      int j;
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      order_in      = order_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_pos_in    = cmp_pos_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      new_count     = count_ff;
      slot_wide     = 32'd0;
      count_wide    = 32'd0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in      = req_word.operation;
               id_in      = req_word.cab_id;
               rd_idx_in  = '0;
               cmp_vld_in = 1'b0;
               found_in   = 1'b0;
               if (req_word.operation inside {lst_pkg::OP_LOOKUP, lst_pkg::OP_ALLOC,
                                              lst_pkg::OP_DEALLOC}) begin
                  state_in = S_SEARCH;
               end else begin
                  state_in = S_ACT;
               end
            end
         end
         S_SEARCH: begin
            // compare the word read last cycle, issue the next read
            if (match) begin
               found_in = 1'b1;
               pos_in   = cmp_pos_ff;
               state_in = S_ACT;
            end else if (rd_idx_ff < count_ff) begin
               rd_en      = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_pos_in = rd_idx_ff[PW-1:0];
            end else if (!cmp_vld_ff) begin
               found_in = 1'b0;
               state_in = S_ACT;
            end else begin
               cmp_vld_in = 1'b0;
            end
         end
         S_ACT: begin
            rsp_word_in.status = lst_pkg::STATUS_MISS;
            slot_wide          = 32'd0;
            if (op_ff == lst_pkg::OP_DEALLOC && found_ff) begin
               // close the gap and park the slot behind the active entries
               new_count = count_ff - 1'b1;
               for (j = 0; j < SLOTS; j++) begin
                  if (j >= int'(pos_ff) && j < int'(new_count)) begin
                     order_in[j] = order_ff[j+1 < SLOTS ? j+1 : j];
                  end else if (j == int'(new_count)) begin
                     order_in[j] = sel_slot;
                  end
               end
               count_in           = new_count;
               rsp_word_in.status = lst_pkg::STATUS_REMOVED;
               slot_wide          = 32'(sel_slot);
            end else if (op_ff inside {lst_pkg::OP_LOOKUP, lst_pkg::OP_ALLOC} &&
                         (found_ff || op_ff == lst_pkg::OP_ALLOC)) begin
               // move the selected slot to front, push the ones ahead down
               for (j = 0; j < SLOTS; j++) begin
                  if (j == 0) begin
                     order_in[j] = sel_slot;
                  end else if (j <= int'(front_pos)) begin
                     order_in[j] = order_ff[j-1];
                  end
               end
               slot_wide = 32'(sel_slot);
               if (found_ff) begin
                  rsp_word_in.status = lst_pkg::STATUS_HIT;
               end else begin
                  wr_en = 1'b1;
                  if (full) begin
                     rsp_word_in.status = lst_pkg::STATUS_OVERLAY;
                  end else begin
                     new_count          = count_ff + 1'b1;
                     count_in           = new_count;
                     rsp_word_in.status = lst_pkg::STATUS_NEW;
                  end
               end
            end
            count_wide              = 32'(new_count);
            rsp_word_in.slot        = slot_wide[lst_pkg::SlotWidth-1:0];
            rsp_word_in.entry_count = count_wide[lst_pkg::CountWidth-1:0];
            rsp_strobe_in           = 1'b1;
            state_in                = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rd_idx_ff     <= '0;
         cmp_vld_ff    <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            order_ff[i] <= PW'(i);
         end
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_idx_ff     <= rd_idx_in;
         cmp_vld_ff    <= cmp_vld_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
         order_ff      <= order_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      cmp_pos_ff  <= cmp_pos_in;
      pos_ff      <= pos_in;
      rsp_word_ff <= rsp_word_in;
   end

   // tag memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem_ff[sel_slot] <= id_ff;
      end
      if (rd_en) begin
         tag_rd_ff <= tag_mem_ff[order_ff[rd_idx_ff[PW-1:0]]];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // a response word always ends the busy period
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response issued while busy");

   // no response in the cycle right after a request is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy && !rsp_strobe))
      else $error("response too early");

   // active entries never exceed the table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SLOTS))
      else $error("entry count out of range");

   // a miss reports slot zero and leaves the count alone
   a_miss_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status == lst_pkg::STATUS_MISS) |->
         (rsp_word.slot == '0 && $stable(count_ff)))
      else $error("miss with nonzero slot or count change");

endmodule
